// ===== hdl/fnv_rph_pkg.sv =====
// shared constants and the hash round function for the record placement hash
// no dependencies
`default_nettype none
package fnv_rph_pkg;
  localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] SLOT_SALT  = 64'h0000deadbeefcafe;
  localparam int unsigned PAGE_W = 32;
  localparam int unsigned SLOT_W = 16;
  localparam logic [31:0] PAGE_COUNT_RESET = 32'd262144;
  localparam logic [15:0] SLOTS_RESET      = 16'd175;
  localparam logic [0:0] REG_PAGE_COUNT = 1'b0;
  localparam logic [0:0] REG_SLOTS      = 1'b1;

  // one hash round step: xor byte then multiply by prime (mod 2^64)
  // prime = 2^40 + 0x1b3, so product is shift-add plus a small multiply
  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    begin
      x = h ^ {56'd0, b};
      fnv_round = (x << 40) + (x * 64'h1b3);
    end
  endfunction
endpackage
`default_nettype wire

// ===== hdl/fnv_rph_hash_cell.sv =====
// one byte round of both fnv-1a hashes, registered
// depends on fnv_rph_pkg
`default_nettype none
module fnv_rph_hash_cell
  import fnv_rph_pkg::*;
#(
  parameter int unsigned BYTE_SEL = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        vld_in,
  input  wire logic [63:0] h1_in,
  input  wire logic [63:0] h2_in,
  input  wire logic [63:0] id_in,
  output logic             vld_out,
  output logic [63:0]      h1_out,
  output logic [63:0]      h2_out,
  output logic [63:0]      id_out
);
  // salt byte that lines up with the byte consumed here
  logic [7:0] id_salted;
  assign id_salted = id_in[7:0] ^ SLOT_SALT[8*BYTE_SEL +: 8];

  // consume low byte and pass the remaining bytes on
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    h1_out <= fnv_round(h1_in, id_in[7:0]);
    h2_out <= fnv_round(h2_in, id_salted);
    id_out <= {8'd0, id_in[63:8]};
  end
endmodule
`default_nettype wire

// ===== hdl/fnv_rph_mod_cell.sv =====
// one restoring-remainder step: shift in a hash bit, subtract divisor if it fits
// depends on fnv_rph_pkg
`default_nettype none
module fnv_rph_mod_cell
  import fnv_rph_pkg::*;
#(
  parameter int unsigned DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vld_in,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [63:0]   num_in,
  input  wire logic [DW-1:0] div_in,
  output logic               vld_out,
  output logic [DW-1:0]      rem_out,
  output logic [63:0]        num_out,
  output logic [DW-1:0]      div_out
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  assign trial = {rem_in, num_in[63]};
  assign diff  = trial - {1'b0, div_in};

  // remainder stays below divisor, so one compare and subtract suffices
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    rem_out <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
    num_out <= {num_in[62:0], 1'b0};
    div_out <= div_in;
  end
endmodule
`default_nettype wire

// ===== hdl/fnv1a_record_placement_hash.sv =====
// top level: eight hash cells then 64 remainder cells per hash
// depends on fnv_rph_pkg, fnv_rph_hash_cell, fnv_rph_mod_cell
//
// channel   ports                         handshake
// config    cfg_we cfg_index cfg_data     write at edge with cfg_we high
// input     start busy rec_key            beat when start && !busy
// result    done page_index slot_index    beat on done, one cycle
//
// one beat per cycle; each beat passes 8 hash cells, then 64 remainder cells
// busy is tied low, the receiver cannot stall
// rst clears the valid chain and loads register resets
// divisor is sampled with the item at entry to the remainder chain
`default_nettype none
module fnv1a_record_placement_hash
  import fnv_rph_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] rec_key,
  output logic             done,
  output logic [31:0]      page_index,
  output logic [15:0]      slot_index
);
  logic [31:0] page_count;
  logic [15:0] slot_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= PAGE_COUNT_RESET;
      slot_count <= SLOTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGE_COUNT: page_count <= cfg_data;
        REG_SLOTS:      slot_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // hash chain
  logic        hv [0:8];
  logic [63:0] h1 [0:8];
  logic [63:0] h2 [0:8];
  logic [63:0] hid [0:8];
  assign hv[0]  = start;
  assign h1[0]  = HASH_BASIS;
  assign h2[0]  = HASH_BASIS;
  assign hid[0] = rec_key;

  for (genvar i = 0; i < 8; i++) begin : g_hash
    fnv_rph_hash_cell #(.BYTE_SEL(i)) u_cell (
      .clk(clk), .rst(rst), .vld_in(hv[i]), .h1_in(h1[i]), .h2_in(h2[i]),
      .id_in(hid[i]), .vld_out(hv[i+1]), .h1_out(h1[i+1]), .h2_out(h2[i+1]),
      .id_out(hid[i+1])
    );
  end

  // remainder chains, one bit of the hash per cell
  logic        pv [0:64];
  logic [31:0] pr [0:64];
  logic [63:0] pn [0:64];
  logic [31:0] pd [0:64];
  logic        sv [0:64];
  logic [15:0] sr [0:64];
  logic [63:0] sn [0:64];
  logic [15:0] sd [0:64];
  assign pv[0] = hv[8];
  assign pr[0] = '0;
  assign pn[0] = h1[8];
  assign pd[0] = page_count;
  assign sv[0] = hv[8];
  assign sr[0] = '0;
  assign sn[0] = h2[8];
  assign sd[0] = slot_count;

  for (genvar j = 0; j < 64; j++) begin : g_mod
    fnv_rph_mod_cell #(.DW(PAGE_W)) u_page (
      .clk(clk), .rst(rst), .vld_in(pv[j]), .rem_in(pr[j]), .num_in(pn[j]),
      .div_in(pd[j]), .vld_out(pv[j+1]), .rem_out(pr[j+1]), .num_out(pn[j+1]),
      .div_out(pd[j+1])
    );
    fnv_rph_mod_cell #(.DW(SLOT_W)) u_slot (
      .clk(clk), .rst(rst), .vld_in(sv[j]), .rem_in(sr[j]), .num_in(sn[j]),
      .div_in(sd[j]), .vld_out(sv[j+1]), .rem_out(sr[j+1]), .num_out(sn[j+1]),
      .div_out(sd[j+1])
    );
  end

  // zero divisor gives zero; the chain otherwise leaves the dividend bits in rem
  assign done       = pv[64];
  assign page_index = (pd[64] == '0) ? '0 : pr[64];
  assign slot_index = (sd[64] == '0) ? '0 : sr[64];

  // remainder never reaches the divisor
  a_page_range: assert property (@(posedge clk) disable iff (rst)
    done && (pd[64] != '0) |-> page_index < pd[64]) else $error("page range");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    done && (sd[64] != '0) |-> slot_index < sd[64]) else $error("slot range");
  a_chain_sync: assert property (@(posedge clk) disable iff (rst)
    pv[64] == sv[64]) else $error("chains out of step");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the record placement hash
// depends on fnv_rph_pkg and fnv1a_record_placement_hash
`default_nettype none
module testbench
  import fnv_rph_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_PAGE_COUNT;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] rec_key = '0;
  logic        done;
  logic [31:0] page_index;
  logic [15:0] slot_index;

  typedef struct packed {
    logic [31:0] page;
    logic [15:0] slot;
  } placement_t;

  // local copy of the divisors
  logic [31:0] pages_now = PAGE_COUNT_RESET;
  logic [15:0] slots_now = SLOTS_RESET;

  placement_t want_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;

  fnv1a_record_placement_hash uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .rec_key(rec_key),
    .done(done), .page_index(page_index), .slot_index(slot_index)
  );

  always #2 clk = ~clk;

  // fnv-1a over eight bytes, low byte first
  function automatic logic [63:0] fnv64(input logic [63:0] v);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int k = 0; k < 8; k++) begin
      h = (h ^ {56'd0, v[8*k +: 8]}) * 64'h00000100000001b3;
    end
    return h;
  endfunction

  function automatic placement_t place_record(input logic [63:0] id);
    placement_t p;
    logic [63:0] h1, h2;
    h1 = fnv64(id);
    h2 = fnv64(id ^ 64'h0000deadbeefcafe);
    p.page = (pages_now == 0) ? 32'd0 : 32'(h1 % {32'd0, pages_now});
    p.slot = (slots_now == 0) ? 16'd0 : 16'(h2 % {48'd0, slots_now});
    return p;
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result page=%0d slot=%0d",
                                       page_index, slot_index);
      end else begin
        placement_t w;
        w = want_q.pop_front();
        if (page_index !== w.page || slot_index !== w.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: page exp %0d got %0d, slot exp %0d got %0d",
                     w.page, page_index, w.slot, slot_index);
        end
      end
    end
  end

  // one input beat, with optional idle cycles in front
  task automatic send_record(input logic [63:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    rec_key <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    want_q = {want_q, place_record(id)};
  endtask

  task automatic drain;
    start <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PAGE_COUNT) pages_now = val;
    else slots_now = val[15:0];
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_divisors;
    send_record(64'd0);
    send_record(64'hffff_ffff_ffff_ffff);
    send_record(64'h0000_deadbeef_cafe);
    for (int b = 0; b < 8; b++) send_record(64'hff << (8*b));
    drain();
  endtask

  task automatic test_extremes;
    logic [31:0] pv [4] = '{32'd1, 32'hffff_ffff, 32'd0, 32'd7};
    logic [15:0] sv [4] = '{16'd1, 16'hffff, 16'd0, 16'd3};
    for (int i = 0; i < 4; i++) begin
      write_reg(REG_PAGE_COUNT, pv[i]);
      write_reg(REG_SLOTS, {16'd0, sv[i]});
      send_record(64'd0);
      send_record(64'hffff_ffff_ffff_ffff);
      send_record(64'h5555_aaaa_5555_aaaa);
      drain();
    end
  endtask

  // random traffic in phases with fresh divisors
  task automatic test_random(input int idle_pct, input int n);
    send_idle_pct = idle_pct;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_PAGE_COUNT, ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096));
      write_reg(REG_SLOTS, {16'd0, 16'($urandom_range(1, 65535))});
      for (int i = 0; i < n; i++) begin
        send_record(($urandom_range(3) == 0) ? 64'($urandom_range(255)) : rand64());
        // occasionally let everything drain mid-stream
        if ($urandom_range(199) == 0) begin
          start <= 1'b0;
          while (want_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    send_idle_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_divisors();
    test_extremes();
    test_random(15, 200);
    test_random(53, 200);
    test_random(0, 200);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
